[hdl/dense_owner_table_swap_remove_macros.svh]
// Assertion macros used by the table's control module.
`ifndef DENSE_OWNER_TABLE_SWAP_REMOVE_MACROS_SVH
`define DENSE_OWNER_TABLE_SWAP_REMOVE_MACROS_SVH

`ifndef SYNTHESIS
`define DOTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dense owner table: same-cycle check failed");
`define DOTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dense owner table: next-cycle check failed");
`else
`define DOTS_ASSERT_SAME(label, clk, rst, ante, cons)
`define DOTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/dots_pkg.sv]
package dots_pkg;

   localparam int SLOT_W = 10;
   localparam int WORD_W = 32;

   typedef enum logic [2:0] {
      FUNC_ADD         = 3'd0,
      FUNC_REMOVE      = 3'd1,
      FUNC_READ_VALUE  = 3'd2,
      FUNC_WRITE_VALUE = 3'd3,
      FUNC_CONTAINS    = 3'd4,
      FUNC_READ_OWNER  = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_OWNER = 2'd3
   } status_type;

   typedef struct packed {
      func_type            func;
      logic [SLOT_W-1:0]   slot_index;
      logic [WORD_W-1:0]   owner_id;
      logic [WORD_W-1:0]   value_in;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_out;
      logic                moved;
      logic [WORD_W-1:0]   owner_out;
      logic [WORD_W-1:0]   value_out;
      logic                found;
   } rsp_type;

   typedef enum logic [1:0] {
      ADDR_REQ  = 2'd0,
      ADDR_HELD = 2'd1,
      ADDR_LAST = 2'd2
   } addr_sel_type;

   typedef struct packed {
      logic         load_req;
      addr_sel_type addr_sel;
      logic         finish;
      logic         move_commit;
   } cmd_type;

   typedef struct packed {
      logic needs_move;
   } stat_type;

endpackage

[hdl/dots_ram.sv]
module dots_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/dots_ctrl.sv]
`include "dense_owner_table_swap_remove_macros.svh"

module dots_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  dots_pkg::stat_type stat,
   output dots_pkg::cmd_type  cmd
);

   import dots_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOVE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.addr_sel = ADDR_HELD;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.addr_sel = ADDR_REQ;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.needs_move) begin
               cmd.addr_sel = ADDR_LAST;
               state_in     = ST_MOVE;
            end else if (rsp_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_MOVE: begin
            cmd.addr_sel = ADDR_LAST;
            if (rsp_free) begin
               cmd.move_commit = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DOTS_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `DOTS_ASSERT_SAME(a_result_slot_free, clock, reset, cmd.finish || cmd.move_commit, rsp_free)
   `DOTS_ASSERT_SAME(a_move_follows_check, clock, reset, state_ff == ST_MOVE,
      $past(state_ff) == ST_CHECK || $past(state_ff) == ST_MOVE)
   `DOTS_ASSERT_SAME(a_move_reads_last, clock, reset, state_ff == ST_MOVE,
      cmd.addr_sel == ADDR_LAST)

endmodule

[hdl/dots_dp.sv]
module dots_dp #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32,
   parameter int OWNER_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  dots_pkg::req_type  req_payload,
   output dots_pkg::rsp_type  rsp_payload,
   input  dots_pkg::cmd_type  cmd,
   output dots_pkg::stat_type stat
);

   import dots_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CW > SLOT_W) ? CW : SLOT_W;

   req_type                req_ff;
   rsp_type                rsp_ff, rsp_in, rsp_new;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          last;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic                   val_we, own_we;
   logic [VALUE_BITS-1:0]  val_wd, val_rd;
   logic [OWNER_BITS-1:0]  own_wd, own_rd, owner_req;
   logic [CMP_W-1:0]       slot_cmp, count_cmp, last_cmp;
   logic                   in_range, owner_match, is_last, full;

   assign last        = CW'(count_ff - CW'(1));
   assign owner_req   = OWNER_BITS'(req_ff.owner_id);
   assign slot_cmp    = CMP_W'(req_ff.slot_index);
   assign count_cmp   = CMP_W'(count_ff);
   assign last_cmp    = CMP_W'(last);
   assign in_range    = slot_cmp < count_cmp;
   assign owner_match = own_rd == owner_req;
   assign is_last     = slot_cmp == last_cmp;
   assign full        = count_ff == CW'(CAPACITY);

   assign stat.needs_move = (req_ff.func == FUNC_REMOVE) && in_range && owner_match && !is_last;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_REQ:  rd_addr = AW'(req_payload.slot_index);
         ADDR_LAST: rd_addr = AW'(last);
         default:   rd_addr = AW'(req_ff.slot_index);
      endcase
   end

   always_comb begin
      rsp_in   = rsp_ff;
      rsp_new  = '0;
      count_in = count_ff;
      val_we   = 1'b0;
      own_we   = 1'b0;
      wr_addr  = AW'(req_ff.slot_index);
      val_wd   = VALUE_BITS'(req_ff.value_in);
      own_wd   = owner_req;
      if (cmd.finish) begin
         unique case (req_ff.func)
            FUNC_ADD: begin
               if (full) begin
                  rsp_new.status = STATUS_FULL;
               end else begin
                  val_we           = 1'b1;
                  own_we           = 1'b1;
                  wr_addr          = AW'(count_ff);
                  rsp_new.slot_out = SLOT_W'(count_ff);
                  count_in         = CW'(count_ff + CW'(1));
               end
            end
            FUNC_REMOVE: begin
               if (!in_range) begin
                  rsp_new.status = STATUS_RANGE;
               end else if (!owner_match) begin
                  rsp_new.status = STATUS_OWNER;
               end else begin
                  count_in = last;
               end
            end
            FUNC_READ_VALUE: begin
               if (!in_range) begin
                  rsp_new.status = STATUS_RANGE;
               end else if (!owner_match) begin
                  rsp_new.status = STATUS_OWNER;
               end else begin
                  rsp_new.value_out = WORD_W'(val_rd);
               end
            end
            FUNC_WRITE_VALUE: begin
               if (!in_range) begin
                  rsp_new.status = STATUS_RANGE;
               end else if (!owner_match) begin
                  rsp_new.status = STATUS_OWNER;
               end else begin
                  val_we = 1'b1;
               end
            end
            FUNC_CONTAINS: begin
               rsp_new.found = in_range && owner_match;
            end
            FUNC_READ_OWNER: begin
               if (!in_range) begin
                  rsp_new.status = STATUS_RANGE;
               end else begin
                  rsp_new.owner_out = WORD_W'(own_rd);
               end
            end
            default: begin
            end
         endcase
         rsp_in = rsp_new;
      end else if (cmd.move_commit) begin
         val_we            = 1'b1;
         own_we            = 1'b1;
         val_wd            = val_rd;
         own_wd            = own_rd;
         rsp_new.moved     = 1'b1;
         rsp_new.slot_out  = SLOT_W'(last);
         rsp_new.owner_out = WORD_W'(own_rd);
         count_in          = last;
         rsp_in            = rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

   dots_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (val_wd),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   dots_ram #(
      .WIDTH (OWNER_BITS),
      .DEPTH (CAPACITY)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (wr_addr),
      .wr_data (own_wd),
      .rd_addr (rd_addr),
      .rd_data (own_rd)
   );

endmodule

[hdl/dense_owner_table_swap_remove.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  dots_pkg::req_type
// rsp_      out        rsp_valid / rsp_ready  dots_pkg::rsp_type
//
// An item is accepted in idle, where its slot is read; a check state then updates the table
// and loads the result register, which raises the result beat.
// A remove that relocates the last entry instead passes from check to a move state, which
// reads that entry, writes it into the removed slot and loads the result. Reset returns to
// idle and clears the entry count; memories are not cleared. A held result beat does not
// block the input; the next item waits in its check or move state until that beat is taken.
module dense_owner_table_swap_remove #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32,
   parameter int OWNER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dots_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dots_pkg::rsp_type rsp_payload
);

   import dots_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dots_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dots_dp #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .OWNER_BITS (OWNER_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import dots_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SLOTS = 1024;

   class owner_table_scoreboard;
      logic [WORD_W-1:0] owner_tbl [SLOTS];
      logic [WORD_W-1:0] value_tbl [SLOTS];
      int unsigned       live_entries;
      rsp_type           expected_q [$];
      int unsigned       errors;

      function new();
         live_entries = 0;
         errors = 0;
      endfunction

      function int unsigned entries();
         return live_entries;
      endfunction

      function logic [WORD_W-1:0] owner_at(int unsigned slot);
         return owner_tbl[slot];
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function status_type slot_status(int unsigned slot, logic [WORD_W-1:0] owner,
                                       bit test_owner);
         if (slot >= live_entries) begin
            return STATUS_RANGE;
         end
         if (test_owner && owner_tbl[slot] != owner) begin
            return STATUS_OWNER;
         end
         return STATUS_OK;
      endfunction

      function void note_request(req_type beat);
         rsp_type     e;
         int unsigned slot;
         int unsigned last;
         e = '0;
         e.status = STATUS_OK;
         slot = 32'(beat.slot_index);
         case (beat.func)
            FUNC_ADD: begin
               if (live_entries >= SLOTS) begin
                  e.status = STATUS_FULL;
               end else begin
                  value_tbl[live_entries] = beat.value_in;
                  owner_tbl[live_entries] = beat.owner_id;
                  e.slot_out = SLOT_W'(live_entries);
                  live_entries++;
               end
            end
            FUNC_REMOVE: begin
               e.status = slot_status(slot, beat.owner_id, 1'b1);
               if (e.status == STATUS_OK) begin
                  last = live_entries - 1;
                  if (slot != last) begin
                     value_tbl[slot] = value_tbl[last];
                     owner_tbl[slot] = owner_tbl[last];
                     e.moved = 1'b1;
                     e.slot_out = SLOT_W'(last);
                     e.owner_out = owner_tbl[last];
                  end
                  live_entries = last;
               end
            end
            FUNC_READ_VALUE: begin
               e.status = slot_status(slot, beat.owner_id, 1'b1);
               if (e.status == STATUS_OK) begin
                  e.value_out = value_tbl[slot];
               end
            end
            FUNC_WRITE_VALUE: begin
               e.status = slot_status(slot, beat.owner_id, 1'b1);
               if (e.status == STATUS_OK) begin
                  value_tbl[slot] = beat.value_in;
               end
            end
            FUNC_CONTAINS: begin
               e.found = (slot_status(slot, beat.owner_id, 1'b1) == STATUS_OK);
            end
            FUNC_READ_OWNER: begin
               e.status = slot_status(slot, beat.owner_id, 1'b0);
               if (e.status == STATUS_OK) begin
                  e.owner_out = owner_tbl[slot];
               end
            end
            default: begin
            end
         endcase
         expected_q.insert(expected_q.size(), e);
      endfunction

      function void report(string field, logic [WORD_W-1:0] exp_val,
                           logic [WORD_W-1:0] got_val);
         errors++;
         $display("%0t: %s expected %h, got %h", $time, field, exp_val, got_val);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, got %p", $time, got);
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status) begin
            report("status", WORD_W'(e.status), WORD_W'(got.status));
         end
         if (got.slot_out !== e.slot_out) begin
            report("slot_out", WORD_W'(e.slot_out), WORD_W'(got.slot_out));
         end
         if (got.moved !== e.moved) begin
            report("moved", WORD_W'(e.moved), WORD_W'(got.moved));
         end
         if (got.owner_out !== e.owner_out) report("owner_out", e.owner_out, got.owner_out);
         if (got.value_out !== e.value_out) report("value_out", e.value_out, got.value_out);
         if (got.found !== e.found) begin
            report("found", WORD_W'(e.found), WORD_W'(got.found));
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   owner_table_scoreboard sb;

   int unsigned cycle_count = 0;
   int unsigned send_calm_left = 0;
   int unsigned recv_calm_left = 0;
   int unsigned recv_hold_left = 0;
   int unsigned beats_taken = 0;
   bit          pressure_done = 1'b0;

   dense_owner_table_swap_remove dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      int unsigned r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_payload);
            beats_taken++;
         end
         r = $urandom_range(0, 99);
         if (recv_hold_left != 0) begin
            recv_hold_left--;
            rsp_ready <= 1'b0;
         end else if (beats_taken >= 150 && !pressure_done) begin
            pressure_done = 1'b1;
            recv_hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (recv_calm_left != 0) begin
            recv_calm_left--;
            rsp_ready <= 1'b1;
         end else if (r < 3) begin
            recv_calm_left = $urandom_range(30, 100);
            rsp_ready <= 1'b1;
         end else if (r < 70) begin
            rsp_ready <= 1'b1;
         end else if (r < 94) begin
            recv_hold_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            recv_hold_left = $urandom_range(10, 50);
            rsp_ready <= 1'b0;
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (send_calm_left != 0) begin
         send_calm_left--;
         return 0;
      end
      if (r < 3) begin
         send_calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(input req_type beat);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(beat);
   endtask

   task automatic send_op(input func_type f, input int unsigned slot,
                          input logic [WORD_W-1:0] owner, input logic [WORD_W-1:0] value);
      req_type beat;
      beat.func = f;
      beat.slot_index = SLOT_W'(slot);
      beat.owner_id = owner;
      beat.value_in = value;
      send_beat(beat);
   endtask

   function automatic req_type random_item(int unsigned add_weight,
                                           int unsigned remove_weight);
      req_type     beat;
      int unsigned n;
      int unsigned pick;
      int unsigned slot;
      n = sb.entries();
      beat.func = FUNC_ADD;
      beat.value_in = $urandom();
      beat.owner_id = $urandom();
      beat.slot_index = SLOT_W'($urandom_range(0, SLOTS - 1));
      if ($urandom_range(0, 99) < 10) begin
         beat.func = func_type'(3'($urandom_range(0, 7)));
         if (n != 0 && $urandom_range(0, 1) == 1) begin
            beat.slot_index = SLOT_W'($urandom_range(0, n - 1));
            if ($urandom_range(0, 1) == 1) beat.owner_id = sb.owner_at(32'(beat.slot_index));
         end
         return beat;
      end
      pick = $urandom_range(0, add_weight + remove_weight + 39);
      if (pick < add_weight) begin
         beat.func = FUNC_ADD;
      end else if (pick < add_weight + remove_weight) begin
         beat.func = FUNC_REMOVE;
      end else begin
         case ((pick - add_weight - remove_weight) / 10)
            0: beat.func = FUNC_READ_VALUE;
            1: beat.func = FUNC_WRITE_VALUE;
            2: beat.func = FUNC_CONTAINS;
            default: beat.func = FUNC_READ_OWNER;
         endcase
      end
      if (n != 0) begin
         case ($urandom_range(0, 3))
            0: slot = n - 1;
            1: slot = 0;
            default: slot = $urandom_range(0, n - 1);
         endcase
         beat.slot_index = SLOT_W'(slot);
         if ($urandom_range(0, 99) < 88) beat.owner_id = sb.owner_at(slot);
      end
      return beat;
   endfunction

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_op(FUNC_READ_VALUE, 0, 32'h0, 32'h0);
      send_op(FUNC_REMOVE, 0, 32'h0, 32'h0);
      send_op(FUNC_CONTAINS, 0, 32'h0, 32'h0);
      send_op(FUNC_READ_OWNER, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(FUNC_ADD, 1023, 32'h0000_0000, 32'h0000_0000);
      send_op(FUNC_ADD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(FUNC_ADD, 0, 32'h1234_5678, 32'hA5A5_A5A5);
      send_op(FUNC_ADD, 0, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
      send_op(FUNC_READ_VALUE, 1, sb.owner_at(1), 32'h0);
      send_op(FUNC_READ_VALUE, 1, 32'h0, 32'h0);
      send_op(FUNC_WRITE_VALUE, 2, sb.owner_at(2), 32'hDEAD_BEEF);
      send_op(FUNC_WRITE_VALUE, 2, 32'h8765_4321, 32'h1111_1111);
      send_op(FUNC_READ_VALUE, 2, sb.owner_at(2), 32'h0);
      send_op(FUNC_CONTAINS, 3, sb.owner_at(3), 32'h0);
      send_op(FUNC_CONTAINS, 3, 32'hFFFF_FFFF, 32'h0);
      send_op(FUNC_CONTAINS, 4, 32'h0, 32'h0);
      send_op(FUNC_READ_OWNER, 0, 32'hFFFF_FFFF, 32'h0);
      send_op(FUNC_READ_OWNER, 4, 32'h0, 32'h0);
      send_op(func_type'(3'd6), 1, sb.owner_at(1), 32'hFFFF_FFFF);
      send_op(func_type'(3'd7), 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(FUNC_REMOVE, 0, 32'hFFFF_FFFF, 32'h0);
      send_op(FUNC_REMOVE, 0, sb.owner_at(0), 32'h0);
      send_op(FUNC_REMOVE, 2, sb.owner_at(2), 32'h0);
      send_op(FUNC_WRITE_VALUE, 2, 32'h0, 32'h0);

      repeat (100) send_beat(random_item(35, 25));

      while (sb.entries() < SLOTS) begin
         send_op(FUNC_ADD, $urandom_range(0, SLOTS - 1), $urandom(), $urandom());
      end
      repeat (3) send_op(FUNC_ADD, $urandom_range(0, SLOTS - 1), $urandom(), $urandom());
      send_op(FUNC_READ_VALUE, SLOTS - 1, sb.owner_at(SLOTS - 1), 32'h0);
      send_op(FUNC_REMOVE, SLOTS - 1, sb.owner_at(SLOTS - 1), 32'h0);
      repeat (40) send_beat(random_item(25, 5));

      repeat (80) send_beat(random_item(10, 50));

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/dots_pkg.sv
hdl/dots_ram.sv
hdl/dots_ctrl.sv
hdl/dots_dp.sv
hdl/dense_owner_table_swap_remove.sv
tb/tb.sv
